@@ rtl/core/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared codes and the sequencer state type for the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   // operation codes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   // placement policies, the unused code acts as first fit
   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_DECODE  = 9'b000000010,
      S_SCAN    = 9'b000000100,
      S_EVAL    = 9'b000001000,
      S_SHIFT   = 9'b000010000,
      S_SPLIT_A = 9'b000100000,
      S_SPLIT_B = 9'b001000000,
      S_RDWAIT  = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

endpackage

@@ rtl/core/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pfa_fit_unit.sv @@
// ----------------------------------------------------------------------------
// pfa_fit_unit
// Shared fit check: one subtract for the leftover and, by mode, a less-than or greater-than
// compare against the best leftover so far, applied to one table entry per cycle.
// ----------------------------------------------------------------------------
module pfa_fit_unit
   import pfa_pkg::*;
#(
   parameter int SIZE_BITS = 16
) (
   input  logic                 entry_used,
   input  logic [SIZE_BITS-1:0] entry_size,
   input  logic [SIZE_BITS-1:0] req_size,
   input  logic [1:0]           fit_mode,
   input  logic                 found,
   input  logic [SIZE_BITS-1:0] best_left,
   output logic                 take,
   output logic [SIZE_BITS-1:0] left
);

   logic [SIZE_BITS:0] diff;
   logic               fits;

   always_comb begin
      diff = {1'b0, entry_size} - {1'b0, req_size};
      left = diff[SIZE_BITS-1:0];
      // borrow out means the entry is too small
      fits = !entry_used && !diff[SIZE_BITS];
      take = fits && (!found
                      || ((fit_mode == MODE_BEST)  && (left < best_left))
                      || ((fit_mode == MODE_WORST) && (left > best_left)));
   end

endmodule

@@ rtl/core/partition_fit_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// partition_fit_allocator_unit
// Ordered partition table with append, first/best/worst fit allocate with
// split, and entry read. Table held in one RAM, walked one entry a cycle.
// ----------------------------------------------------------------------------
// cycles per item vary by operation: append writes in decode, read adds a RAM wait state,
//    allocate scans every entry, then shifts the entries above the pick and writes the
//    split pair; a failed allocate skips shift and split; a stalled response adds its wait
// one item at a time; the shift uses the read and write ports together, the scan one read a cycle
// reset clears entry count, fit mode and control; the table RAM is not cleared
// since only entries below the count are ever read
module partition_fit_allocator_unit
   import pfa_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int SIZE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_size,
   input  logic [5:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_placed_index,
   output logic [15:0] rsp_entry_size,
   output logic        rsp_entry_used,
   output logic [6:0]  rsp_entry_total
);

   localparam int AW  = $clog2(MAX_ENTRIES);
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int XW  = (CW > 7) ? CW : 7;
   localparam int SW  = SIZE_BITS;
   localparam int SXW = (SW > 16) ? SW : 16;

   state_type         state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [1:0]        op_ff, op_in;
   logic [SW-1:0]     rsize_ff, rsize_in;
   logic [5:0]        ridx_ff, ridx_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [AW-1:0]     chk_idx_ff, chk_idx_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     pick_ff, pick_in;
   logic [SW-1:0]     best_ff, best_in;
   logic [AW-1:0]     src_ff, src_in;
   logic              mv_valid_ff, mv_valid_in;
   logic [AW-1:0]     mv_dst_ff, mv_dst_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [5:0]        res_index_ff, res_index_in;
   logic [15:0]       res_size_ff, res_size_in;
   logic              res_used_ff, res_used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_index_ff, rsp_index_in;
   logic [15:0]       rsp_size_ff, rsp_size_in;
   logic              rsp_used_ff, rsp_used_in;
   logic [6:0]        rsp_total_ff, rsp_total_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [SW:0]       wr_data, rd_data;
   logic              fit_take;
   logic [SW-1:0]     fit_left;

   logic [XW-1:0]     count_x, idx_x, pick_x, cnt_old_x;
   logic [CW-1:0]     cnt_m1;
   logic [SXW-1:0]    rsize_x, best_x, rd_size_x;

   pfa_ram #(
      .WIDTH (SW + 1),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfa_fit_unit #(
      .SIZE_BITS (SW)
   ) u_fit (
      .entry_used (rd_data[SW]),
      .entry_size (rd_data[SW-1:0]),
      .req_size   (rsize_ff),
      .fit_mode   (mode_ff),
      .found      (found_ff),
      .best_left  (best_ff),
      .take       (fit_take),
      .left       (fit_left)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      count_x   = XW'(count_ff);
      cnt_old_x = XW'(count_ff);
      idx_x     = XW'(ridx_ff);
      pick_x    = XW'(pick_ff);
      cnt_m1    = count_ff - CW'(1);
      rsize_x   = SXW'(rsize_ff);
      best_x    = SXW'(best_ff);
      rd_size_x = SXW'(rd_data[SW-1:0]);

      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      rsize_in      = rsize_ff;
      ridx_in       = ridx_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      src_in        = src_ff;
      mv_valid_in   = 1'b0;
      mv_dst_in     = mv_dst_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_size_in   = res_size_ff;
      res_used_in   = res_used_ff;

      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = {1'b0, rsize_ff};
      rd_en   = 1'b0;
      rd_addr = idx_x[AW-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_total_in  = rsp_total_ff;

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               rsize_in = SW'(req_size);
               ridx_in  = req_entry_index;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_status_in = ST_OK;
            res_index_in  = '0;
            res_size_in   = '0;
            res_used_in   = 1'b0;
            state_in      = S_RESP;
            unique case (op_ff)
               OP_APPEND: begin
                  if (count_ff >= CW'(MAX_ENTRIES)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en        = 1'b1;
                     wr_addr      = count_ff[AW-1:0];
                     wr_data      = {1'b0, rsize_ff};
                     count_in     = count_ff + CW'(1);
                     res_index_in = cnt_old_x[5:0];
                     res_size_in  = rsize_x[15:0];
                  end
               end
               OP_ALLOC: begin
                  issue_in = '0;
                  found_in = 1'b0;
                  best_in  = '0;
                  pick_in  = '0;
                  state_in = S_SCAN;
               end
               OP_READ: begin
                  if (idx_x >= count_x) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_x[AW-1:0];
                     state_in = S_RDWAIT;
                  end
               end
               default: begin
                  // unknown operation answers ok with the table untouched
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_RDWAIT: begin
            res_index_in = idx_x[5:0];
            res_size_in  = rd_size_x[15:0];
            res_used_in  = rd_data[SW];
            state_in     = S_RESP;
         end
         S_SCAN: begin
            // read issue runs one entry ahead of the fit check
            if (chk_valid_ff && fit_take) begin
               found_in = 1'b1;
               pick_in  = chk_idx_ff;
               best_in  = fit_left;
            end
            if (issue_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = issue_ff[AW-1:0];
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[AW-1:0];
               issue_in     = issue_ff + CW'(1);
            end else if (!chk_valid_ff) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_index_in = '0;
            res_size_in  = '0;
            res_used_in  = 1'b0;
            if (!found_ff) begin
               res_status_in = ST_NOFIT;
               state_in      = S_RESP;
            end else if (count_ff >= CW'(MAX_ENTRIES)) begin
               res_status_in = ST_FULL;
               state_in      = S_RESP;
            end else begin
               src_in   = cnt_m1[AW-1:0];
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // move entries above the pick up one place, top first
            if (mv_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = mv_dst_ff;
               wr_data = rd_data;
            end
            if (src_ff > pick_ff) begin
               rd_en       = 1'b1;
               rd_addr     = src_ff;
               mv_valid_in = 1'b1;
               mv_dst_in   = src_ff + AW'(1);
               src_in      = src_ff - AW'(1);
            end else if (!mv_valid_ff) begin
               state_in = S_SPLIT_A;
            end
         end
         S_SPLIT_A: begin
            wr_en    = 1'b1;
            wr_addr  = pick_ff;
            wr_data  = {1'b1, rsize_ff};
            state_in = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            wr_en         = 1'b1;
            wr_addr       = pick_ff + AW'(1);
            wr_data       = {1'b0, best_ff};
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            res_index_in  = pick_x[5:0];
            res_size_in   = best_x[15:0];
            res_used_in   = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_size_in   = res_size_ff;
               rsp_used_in   = res_used_ff;
               rsp_total_in  = count_x[6:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_FIRST;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         mv_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         mv_valid_ff  <= mv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rsize_ff      <= rsize_in;
      ridx_ff       <= ridx_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      src_ff        <= src_in;
      mv_dst_ff     <= mv_dst_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_size_ff   <= res_size_in;
      res_used_ff   <= res_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_placed_index = rsp_index_ff;
   assign rsp_entry_size   = rsp_size_ff;
   assign rsp_entry_used   = rsp_used_ff;
   assign rsp_entry_total  = rsp_total_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $past(reset) || (count_ff == $past(count_ff))
      || (count_ff == ($past(count_ff) + CW'(1))))
      else $error("entry count moved by more than one");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |->
      ((rsp_index_ff == '0) && (rsp_size_ff == '0) && !rsp_used_ff))
      else $error("failed transfer carries nonzero fields");

   a_shift_above_pick: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT) && mv_valid_ff) |->
      ({1'b0, mv_dst_ff} > ({1'b0, pick_ff} + (AW + 1)'(1))))
      else $error("shift write lands on the split entries");

   a_split_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (found_ff && (pick_ff < count_ff[AW-1:0] ||
      count_ff >= CW'(MAX_ENTRIES))))
      else $error("shift without a fitting entry");

endmodule
